// ===== src/wsd_pkg.sv =====
// Package for the WebSocket frame deframer.
// Holds the parse phase encoding, result kind codes and length code constants.
// No dependencies.
package wsd_pkg;

    typedef enum logic [6:0] {
        PH_HDR0  = 7'b0000001,
        PH_HDR1  = 7'b0000010,
        PH_EXT16 = 7'b0000100,
        PH_EXT64 = 7'b0001000,
        PH_KEY   = 7'b0010000,
        PH_DATA  = 7'b0100000,
        PH_ERR   = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

// ===== src/websocket_frame_deframer_top.sv =====
// WebSocket frame deframer, receive side: header parse, unmasking, error on unmasked frame.
// Depends on wsd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_byte) carries the connection stream, one byte per
//   request. Output channel (out_valid/out_ready and the result fields) gives at most one
//   result per input byte: a header result once the masking key is complete, one result
//   per unmasked payload byte (last set on the final one, or on the header of an empty
//   frame), or a single error result when a frame arrives without MASK.
//   Latency: a result appears on the output register the cycle after its byte is taken.
//   Throughput: one byte per cycle while in_ready is high; the parse state advances in the
//   cycle the byte is accepted; the output register loads then only if it gives a result.
//   Stall: while a result waits with out_ready low, in_ready drops; otherwise bytes that
//   give no result (header, length and key bytes) are taken every cycle.
//   After an error the block keeps taking bytes and drops them until reset.
//   Reset (rst_n low, asynchronous) returns the parser to the first header byte, clears
//   the held header fields and the continuation opcode, and empties the output register.
module websocket_frame_deframer_top
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic        fin_bit,
    output logic [2:0]  reserved_flags,
    output logic [3:0]  frame_kind,
    output logic [63:0] frame_length,
    output logic        last
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic        fin_reg, fin_next;
    logic [2:0]  rsv_reg, rsv_next;
    logic [3:0]  opc_reg, opc_next;
    logic [3:0]  cont_opc_reg, cont_opc_next;
    logic [63:0] len_reg, len_next;
    logic [63:0] done_reg, done_next;
    logic [31:0] key_reg, key_next;
    logic        mask_reg, mask_next;

    logic        out_valid_reg;
    kind_t       kind_reg;
    logic [7:0]  data_reg;
    logic        fin_out_reg;
    logic [2:0]  rsv_out_reg;
    logic [3:0]  opc_out_reg;
    logic [63:0] len_out_reg;
    logic        last_reg;

    logic        in_fire;
    logic        emit;
    kind_t       emit_kind;
    logic [7:0]  emit_data;
    logic        emit_last;
    logic [7:0]  key_byte;
    logic [6:0]  len_code;
    logic [3:0]  field_limit;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign len_code = in_byte[6:0];

    always_comb
    begin
        case (done_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        fin_next      = fin_reg;
        rsv_next      = rsv_reg;
        opc_next      = opc_reg;
        cont_opc_next = cont_opc_reg;
        len_next      = len_reg;
        done_next     = done_reg;
        key_next      = key_reg;
        mask_next     = mask_reg;
        emit          = 1'b0;
        emit_kind     = KIND_HEADER;
        emit_data     = 8'd0;
        emit_last     = 1'b0;
        field_limit   = (phase_reg == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES;

        unique case (phase_reg)
            PH_HDR0:
            begin
                fin_next  = in_byte[7];
                rsv_next  = in_byte[6:4];
                done_next = 64'd0;
                if (in_byte[3:0] != 4'd0)
                begin
                    opc_next      = in_byte[3:0];
                    cont_opc_next = in_byte[3:0];
                end
                else
                begin
                    opc_next = cont_opc_reg;
                end
                phase_next = PH_HDR1;
            end
            PH_HDR1:
            begin
                mask_next  = in_byte[7];
                count_next = 4'd0;
                if (len_code == LEN_CODE_EXT16)
                begin
                    len_next   = 64'd0;
                    phase_next = PH_EXT16;
                end
                else if (len_code == LEN_CODE_EXT64)
                begin
                    len_next   = 64'd0;
                    phase_next = PH_EXT64;
                end
                else
                begin
                    len_next = {57'd0, len_code};
                    if (in_byte[7])
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                        emit       = 1'b1;
                        emit_kind  = KIND_ERROR;
                    end
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                len_next   = {len_reg[55:0], in_byte};
                count_next = count_reg + 4'd1;
                if (count_next >= field_limit)
                begin
                    count_next = 4'd0;
                    if (mask_reg)
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                        emit       = 1'b1;
                        emit_kind  = KIND_ERROR;
                    end
                end
            end
            PH_KEY:
            begin
                key_next   = {key_reg[23:0], in_byte};
                count_next = count_reg + 4'd1;
                if (count_next >= KEY_BYTES)
                begin
                    count_next = 4'd0;
                    done_next  = 64'd0;
                    emit       = 1'b1;
                    emit_kind  = KIND_HEADER;
                    if (len_reg == 64'd0)
                    begin
                        phase_next = PH_HDR0;
                        emit_last  = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                done_next = done_reg + 64'd1;
                emit      = 1'b1;
                emit_kind = KIND_PAYLOAD;
                emit_data = in_byte ^ key_byte;
                emit_last = (done_next >= len_reg);
                if (emit_last)
                begin
                    phase_next = PH_HDR0;
                end
            end
            PH_ERR:
            begin
                phase_next = PH_ERR;
            end
            default:
            begin
                phase_next = PH_ERR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            count_reg    <= 4'd0;
            fin_reg      <= 1'b0;
            rsv_reg      <= 3'd0;
            opc_reg      <= 4'd0;
            cont_opc_reg <= 4'd0;
            len_reg      <= 64'd0;
            done_reg     <= 64'd0;
            key_reg      <= 32'd0;
            mask_reg     <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            fin_reg      <= fin_next;
            rsv_reg      <= rsv_next;
            opc_reg      <= opc_next;
            cont_opc_reg <= cont_opc_next;
            len_reg      <= len_next;
            done_reg     <= done_next;
            key_reg      <= key_next;
            mask_reg     <= mask_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            kind_reg    <= emit_kind;
            data_reg    <= emit_data;
            fin_out_reg <= fin_next;
            rsv_out_reg <= rsv_next;
            opc_out_reg <= opc_next;
            len_out_reg <= len_next;
            last_reg    <= emit_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign payload_byte   = data_reg;
    assign fin_bit        = fin_out_reg;
    assign reserved_flags = rsv_out_reg;
    assign frame_kind     = opc_out_reg;
    assign frame_length   = len_out_reg;
    assign last           = last_reg;

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERR |=> phase_reg == PH_ERR)
        else $error("error phase left without reset");

    a_data_gives_payload: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && phase_reg == PH_DATA |=> out_valid && kind == KIND_PAYLOAD)
        else $error("payload byte did not produce a payload result");

    a_hdr_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (phase_reg == PH_HDR0 || phase_reg == PH_ERR) && !out_valid
        |=> !out_valid)
        else $error("result produced for a byte that carries none");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < EXT64_BYTES)
        else $error("field byte count out of range");

endmodule

// ===== tb/sv/tb_websocket_frame_deframer_top.sv =====
// Testbench for websocket_frame_deframer_top: byte-stream frames in, header/payload/error
// results out, checked by an in-bench parser or typed rows; random idling on both sides.
// Depends on wsd_pkg and websocket_frame_deframer_top.
module tb_websocket_frame_deframer_top
    import wsd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] OPC_CONTINUATION = 4'h0;
    localparam logic [3:0] OPC_BINARY       = 4'h2;
    localparam logic [3:0] OPC_PONG         = 4'hA;
    localparam logic       MASK_SET         = 1'b1;
    localparam logic       MASK_CLEAR       = 1'b0;
    localparam int         TARGET_BYTES     = 1750;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic        fin;
        logic [2:0]  rsv;
        logic [3:0]  opcode;
        logic [63:0] length;
        logic        last;
    } frame_result_t;

    typedef struct {
        logic [7:0]    b;
        bit            typed;
        frame_result_t want;
    } stim_row_t;

    localparam frame_result_t NO_RESULT = '0;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        fin_bit;
    logic [2:0]  reserved_flags;
    logic [3:0]  frame_kind;
    logic [63:0] frame_length;
    logic        last;

    phase_t      parse_phase;
    logic [3:0]  field_count;
    logic        held_fin;
    logic [2:0]  held_rsv;
    logic [3:0]  held_opcode;
    logic [3:0]  cont_opcode;
    logic [63:0] held_length;
    logic [63:0] data_count;
    logic [31:0] held_key;
    logic        held_mask;

    frame_result_t pending_results[$];
    stim_row_t     stim_rows[$];
    int            n_directed;
    int            bytes_sent;
    int            mismatches;
    bit            tx_burst;
    bit            rx_burst;
    bit            long_hold_req;

    websocket_frame_deframer_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .fin_bit        (fin_bit),
        .reserved_flags (reserved_flags),
        .frame_kind     (frame_kind),
        .frame_length   (frame_length),
        .last           (last)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic frame_result_t make_result(input kind_t k, input logic [7:0] d,
                                                  input logic f, input logic [2:0] rs,
                                                  input logic [3:0] op, input logic [63:0] ln,
                                                  input logic l);
        frame_result_t r;
        r.kind   = k;
        r.data   = d;
        r.fin    = f;
        r.rsv    = rs;
        r.opcode = op;
        r.length = ln;
        r.last   = l;
        return r;
    endfunction

    task automatic deframe_byte(input logic [7:0] b, output bit got, output frame_result_t r);
        bit         len_complete;
        logic [7:0] kb;
        got = 1'b0;
        r = NO_RESULT;
        len_complete = 1'b0;
        case (parse_phase)
            PH_HDR0:
            begin
                held_fin = b[7];
                held_rsv = b[6:4];
                if (b[3:0] != OPC_CONTINUATION)
                begin
                    cont_opcode = b[3:0];
                    held_opcode = b[3:0];
                end
                else
                    held_opcode = cont_opcode;
                data_count = '0;
                parse_phase = PH_HDR1;
            end
            PH_HDR1:
            begin
                held_mask = b[7];
                field_count = '0;
                if (b[6:0] == LEN_CODE_EXT16)
                begin
                    held_length = '0;
                    parse_phase = PH_EXT16;
                end
                else if (b[6:0] == LEN_CODE_EXT64)
                begin
                    held_length = '0;
                    parse_phase = PH_EXT64;
                end
                else
                begin
                    held_length = 64'(b[6:0]);
                    len_complete = 1'b1;
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                held_length = {held_length[55:0], b};
                field_count = field_count + 4'd1;
                if (field_count >= ((parse_phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES))
                    len_complete = 1'b1;
            end
            PH_KEY:
            begin
                held_key = {held_key[23:0], b};
                field_count = field_count + 4'd1;
                if (field_count == KEY_BYTES)
                begin
                    field_count = '0;
                    data_count = '0;
                    got = 1'b1;
                    r = make_result(KIND_HEADER, 8'h00, held_fin, held_rsv, held_opcode,
                                    held_length, held_length == 64'd0);
                    parse_phase = (held_length == 64'd0) ? PH_HDR0 : PH_DATA;
                end
            end
            PH_DATA:
            begin
                kb = held_key[8 * (3 - int'(data_count[1:0])) +: 8];
                data_count = data_count + 64'd1;
                got = 1'b1;
                r = make_result(KIND_PAYLOAD, b ^ kb, held_fin, held_rsv, held_opcode,
                                held_length, data_count >= held_length);
                if (data_count >= held_length)
                    parse_phase = PH_HDR0;
            end
            default:
                parse_phase = PH_ERR;
        endcase
        if (len_complete)
        begin
            field_count = '0;
            if (held_mask)
                parse_phase = PH_KEY;
            else
            begin
                parse_phase = PH_ERR;
                got = 1'b1;
                r = make_result(KIND_ERROR, 8'h00, held_fin, held_rsv, held_opcode,
                                held_length, 1'b0);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 50)
            $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input frame_result_t want);
        if (kind !== want.kind)
            report_mismatch("kind", 64'(kind), 64'(want.kind));
        if (payload_byte !== want.data)
            report_mismatch("payload_byte", 64'(payload_byte), 64'(want.data));
        if (fin_bit !== want.fin)
            report_mismatch("fin_bit", 64'(fin_bit), 64'(want.fin));
        if (reserved_flags !== want.rsv)
            report_mismatch("reserved_flags", 64'(reserved_flags), 64'(want.rsv));
        if (frame_kind !== want.opcode)
            report_mismatch("frame_kind", 64'(frame_kind), 64'(want.opcode));
        if (frame_length !== want.length)
            report_mismatch("frame_length", frame_length, want.length);
        if (last !== want.last)
            report_mismatch("last", 64'(last), 64'(want.last));
    endtask

    task automatic add_row(input logic [7:0] b, input bit typed, input frame_result_t want);
        stim_row_t row;
        row.b = b;
        row.typed = typed;
        row.want = want;
        stim_rows.push_back(row);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed, input frame_result_t want);
        int            gap;
        bit            got;
        frame_result_t r;
        if ($urandom_range(0, 29) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (in_ready !== 1'b1);
        deframe_byte(b, got, r);
        if (typed)
            pending_results.push_back(want);
        else if (got)
            pending_results.push_back(r);
        bytes_sent++;
    endtask

    task automatic walk_rows(input int from, input int upto);
        for (int i = from; i < upto; i++)
            send_byte(stim_rows[i].b, stim_rows[i].typed, stim_rows[i].want);
    endtask

    task automatic send_random_frame();
        logic [7:0]  hdr0;
        logic [63:0] flen;
        logic [31:0] key;
        int          pick;
        hdr0 = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 3)
            hdr0[3:0] = OPC_CONTINUATION;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            flen = 64'($urandom_range(0, 12));
        else if (pick < 58)
            flen = 64'($urandom_range(100, 125));
        else if (pick < 82)
            flen = 64'($urandom_range(0, 40));
        else if (pick < 85)
            flen = 64'($urandom_range(200, 600));
        else
            flen = 64'($urandom_range(0, 30));
        send_byte(hdr0, 1'b0, NO_RESULT);
        if (pick < 58)
            send_byte({MASK_SET, flen[6:0]}, 1'b0, NO_RESULT);
        else if (pick < 85)
        begin
            send_byte({MASK_SET, LEN_CODE_EXT16}, 1'b0, NO_RESULT);
            send_byte(flen[15:8], 1'b0, NO_RESULT);
            send_byte(flen[7:0], 1'b0, NO_RESULT);
        end
        else
        begin
            send_byte({MASK_SET, LEN_CODE_EXT64}, 1'b0, NO_RESULT);
            for (int i = 7; i >= 0; i--)
                send_byte(flen[8 * i +: 8], 1'b0, NO_RESULT);
        end
        key = $urandom;
        for (int i = 3; i >= 0; i--)
            send_byte(key[8 * i +: 8], 1'b0, NO_RESULT);
        for (longint n = 0; n < longint'(flen); n++)
            send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
    endtask

    // receiver: random stall per result, one long hold-off on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                stall = 400;
                long_hold_req = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 29) == 0)
                    rx_burst = !rx_burst;
                stall = rx_burst ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, kind", 64'(kind), '0);
            else
                check_result(pending_results.pop_front());
        end
    end

    initial
    begin
        #10_000_000;
        $display("[websocket_frame_deframer_top] ERROR");
        $finish;
    end

    initial
    begin
        int frame_no;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = 8'h00;
        parse_phase = PH_HDR0;
        field_count = '0;
        held_fin = 1'b0;
        held_rsv = '0;
        held_opcode = '0;
        cont_opcode = '0;
        held_length = '0;
        data_count = '0;
        held_key = '0;
        held_mask = 1'b0;
        bytes_sent = 0;
        mismatches = 0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        long_hold_req = 1'b0;

        // empty frame, continuation right after reset
        add_row({1'b1, 3'b000, OPC_CONTINUATION}, 1'b0, NO_RESULT);
        add_row({MASK_SET, 7'd0}, 1'b0, NO_RESULT);
        add_row(8'h00, 1'b0, NO_RESULT);
        add_row(8'h00, 1'b0, NO_RESULT);
        add_row(8'h00, 1'b0, NO_RESULT);
        add_row(8'h00, 1'b1, make_result(KIND_HEADER, 8'h00, 1'b1, 3'b000,
                                         OPC_CONTINUATION, 64'd0, 1'b1));
        // control opcode, all reserved bits, 16-bit length, all-ones key
        add_row({1'b0, 3'b111, OPC_PONG}, 1'b0, NO_RESULT);
        add_row({MASK_SET, LEN_CODE_EXT16}, 1'b0, NO_RESULT);
        add_row(8'h00, 1'b0, NO_RESULT);
        add_row(8'h03, 1'b0, NO_RESULT);
        add_row(8'hFF, 1'b0, NO_RESULT);
        add_row(8'hFF, 1'b0, NO_RESULT);
        add_row(8'hFF, 1'b0, NO_RESULT);
        add_row(8'hFF, 1'b1, make_result(KIND_HEADER, 8'h00, 1'b0, 3'b111,
                                         OPC_PONG, 64'd3, 1'b0));
        add_row(8'h00, 1'b1, make_result(KIND_PAYLOAD, 8'hFF, 1'b0, 3'b111,
                                         OPC_PONG, 64'd3, 1'b0));
        add_row(8'hFF, 1'b1, make_result(KIND_PAYLOAD, 8'h00, 1'b0, 3'b111,
                                         OPC_PONG, 64'd3, 1'b0));
        add_row(8'h5A, 1'b1, make_result(KIND_PAYLOAD, 8'hA5, 1'b0, 3'b111,
                                         OPC_PONG, 64'd3, 1'b1));
        // continuation takes the control opcode
        add_row({1'b1, 3'b000, OPC_CONTINUATION}, 1'b0, NO_RESULT);
        add_row({MASK_SET, 7'd1}, 1'b0, NO_RESULT);
        add_row(8'h01, 1'b0, NO_RESULT);
        add_row(8'h02, 1'b0, NO_RESULT);
        add_row(8'h03, 1'b0, NO_RESULT);
        add_row(8'h04, 1'b0, NO_RESULT);
        add_row(8'h3C, 1'b0, NO_RESULT);
        n_directed = stim_rows.size();
        // unmasked frame with all-ones 64-bit length closes the run, then dropped bytes
        add_row({1'b1, 3'b111, OPC_BINARY}, 1'b0, NO_RESULT);
        add_row({MASK_CLEAR, LEN_CODE_EXT64}, 1'b0, NO_RESULT);
        for (int i = 0; i < 7; i++)
            add_row(8'hFF, 1'b0, NO_RESULT);
        add_row(8'hFF, 1'b1, make_result(KIND_ERROR, 8'h00, 1'b1, 3'b111,
                                         OPC_BINARY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
        add_row(8'h00, 1'b0, NO_RESULT);
        add_row(8'hFF, 1'b0, NO_RESULT);
        add_row({MASK_SET, 7'd1}, 1'b0, NO_RESULT);
        add_row(8'h3C, 1'b0, NO_RESULT);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        walk_rows(0, n_directed);
        frame_no = 0;
        while (bytes_sent < TARGET_BYTES)
        begin
            if (frame_no == 20)
                long_hold_req = 1'b1;
            if (frame_no == 10)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (pending_results.size() != 0);
            end
            send_random_frame();
            frame_no++;
        end
        walk_rows(n_directed, stim_rows.size());
        in_valid <= 1'b0;

        do @(posedge clk); while (pending_results.size() != 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[websocket_frame_deframer_top] OK");
        else
            $display("[websocket_frame_deframer_top] ERROR");
        $finish;
    end

endmodule
